[rtl/rgds_pkg.sv]
// Shared types, constants and register codes for the rpm/gear display serializer.
`default_nettype none

package rgds_pkg;

   localparam int FRAME_BITS          = 24;
   localparam int BAR_BITS            = 10;
   localparam int THRESH_COUNT        = 5;
   localparam int SETUP_DELAY_DEFAULT = 16;
   localparam int CSR_DATA_BITS       = 56;

   localparam logic [BAR_BITS-1:0] BAR_ALL_OFF       = 10'h3ff;
   localparam logic [55:0]         GEAR_TABLE_RESET  = 56'h0;
   localparam logic [39:0]         THRESH_RESET      = 40'h9B8B7C6C5C;
   localparam logic [7:0]          SHIFT_LIMIT_RESET = 8'd172;

   localparam logic [2:0] GEAR_BLANK = 3'd0;

   typedef enum logic [1:0] {
      CSR_GEAR_TABLE  = 2'd0,
      CSR_THRESHOLDS  = 2'd1,
      CSR_SHIFT_LIMIT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] rpm_level;
      logic [2:0] gear_index;
      logic [5:0] flag_bits;
      logic       blink_phase;
   } req_type;

   typedef struct packed {
      logic data_bit;
      logic last_bit;
   } rsp_type;

   typedef struct packed {
      logic [55:0] gear_segment_table;
      logic [39:0] rpm_thresholds;
      logic [7:0]  shift_limit;
   } cfg_type;

   typedef logic [FRAME_BITS-1:0] frame_type;

   typedef struct packed {
      logic      valid;
      frame_type frame;
   } frame_beat_type;

endpackage

`default_nettype wire

[rtl/rgds_csr_regs.sv]
// Configuration registers: gear segment table, rpm thresholds and shift limit.
`default_nettype none

module rgds_csr_regs
   import rgds_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [1:0]               csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_GEAR_TABLE:  cfg_in.gear_segment_table = csr_wdata[55:0];
            CSR_THRESHOLDS:  cfg_in.rpm_thresholds     = csr_wdata[39:0];
            CSR_SHIFT_LIMIT: cfg_in.shift_limit        = csr_wdata[7:0];
            default:         cfg_in = cfg_ff;  // unmapped index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gear_segment_table <= GEAR_TABLE_RESET;
         cfg_ff.rpm_thresholds     <= THRESH_RESET;
         cfg_ff.shift_limit        <= SHIFT_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[rtl/rgds_frame_builder.sv]
// Frame builder: forms the 24-bit frame from one request and holds it for the serializer.
`default_nettype none

module rgds_frame_builder
   import rgds_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   input  wire cfg_type cfg,
   input  wire logic    frame_take,
   output frame_beat_type frame_out
);

   logic              pend_valid_ff;
   logic              pend_valid_in;
   frame_type         pend_frame_ff;
   frame_type         pend_frame_in;
   logic [BAR_BITS-1:0] bar;
   logic [7:0]        gear_byte;
   logic [2:0]        gear_slot;
   logic              run;
   logic [7:0]        thr;
   logic              req_accept;

   // Walk the thresholds in order; stop lighting pairs at the first miss. Above the shift limit the whole bar blinks.
   always_comb begin
      bar = BAR_ALL_OFF;
      run = 1'b1;
      thr = '0;
      for (int c = 0; c < THRESH_COUNT; c++) begin
         thr = cfg.rpm_thresholds[8*c +: 8];
         run = run && (req_data.rpm_level > thr);
         if (run) begin
            bar[c]              = 1'b0;
            bar[BAR_BITS-1-c]   = 1'b0;
         end
      end
      if (req_data.rpm_level > cfg.shift_limit) begin
         bar = req_data.blink_phase ? BAR_ALL_OFF : '0;
      end
   end

   assign gear_slot = req_data.gear_index - 3'd1;

   always_comb begin
      if (req_data.gear_index == GEAR_BLANK) begin
         gear_byte = 8'h00;
      end else begin
         gear_byte = cfg.gear_segment_table[8*gear_slot +: 8];
      end
   end

   assign req_ready  = !pend_valid_ff || frame_take;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_frame_in = pend_frame_ff;
      if (req_accept) begin
         pend_valid_in = 1'b1;
         pend_frame_in = {gear_byte, ~req_data.flag_bits, bar};
      end else if (frame_take) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_frame_ff <= pend_frame_in;
   end

   assign frame_out.valid = pend_valid_ff;
   assign frame_out.frame = pend_frame_ff;

   a_pend_holds: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff && !frame_take |=> pend_valid_ff && $stable(pend_frame_ff))
      else $error("pending frame lost before the serializer took it");

endmodule

`default_nettype wire

[rtl/rgds_serializer.sv]
// Serializer: shifts a frame out MSB first, one bit per beat after a setup delay.
`default_nettype none

module rgds_serializer
   import rgds_pkg::*;
#(
   parameter int SETUP_DELAY_CYCLES = SETUP_DELAY_DEFAULT
)(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire frame_beat_type frame_in,
   output logic          frame_take,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp_data
);

   localparam int DW = $clog2(SETUP_DELAY_CYCLES + 1);
   localparam int CW = $clog2(FRAME_BITS);

   logic            busy_ff, busy_in;
   frame_type       shift_ff, shift_in;
   logic [CW-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DW-1:0]   delay_ff, delay_in;
   logic            last;
   logic            rsp_accept;

   assign last       = bit_cnt_ff == CW'(FRAME_BITS - 1);
   assign rsp_valid  = busy_ff && (delay_ff == '0);
   assign rsp_accept = rsp_valid && rsp_ready;
   assign frame_take = frame_in.valid && (!busy_ff || (rsp_accept && last));

   assign rsp_data.data_bit = shift_ff[FRAME_BITS-1];
   assign rsp_data.last_bit = last;

   always_comb begin
      busy_in    = busy_ff;
      shift_in   = shift_ff;
      bit_cnt_in = bit_cnt_ff;
      delay_in   = delay_ff;
      if (frame_take) begin
         busy_in    = 1'b1;
         shift_in   = frame_in.frame;
         bit_cnt_in = '0;
         delay_in   = DW'(SETUP_DELAY_CYCLES);
      end else if (rsp_accept && last) begin
         busy_in = 1'b0;
      end else if (rsp_accept) begin
         shift_in   = {shift_ff[FRAME_BITS-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff + CW'(1);
         delay_in   = DW'(SETUP_DELAY_CYCLES);
      end else if (busy_ff && (delay_ff != '0)) begin
         delay_in = delay_ff - DW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         bit_cnt_ff <= '0;
         delay_ff   <= '0;
      end else begin
         busy_ff    <= busy_in;
         bit_cnt_ff <= bit_cnt_in;
         delay_ff   <= delay_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> bit_cnt_ff <= CW'(FRAME_BITS - 1))
      else $error("bit counter ran past the frame");

   a_setup_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && !last |=> busy_ff && !rsp_valid)
      else $error("next bit shown without a setup delay");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && last && !frame_in.valid |=> !busy_ff)
      else $error("serializer stayed busy after the last bit");

endmodule

`default_nettype wire

[rtl/rpm_gear_display_serializer_top.sv]
// Top level of the rpm/gear display serializer for an LED shift-register chain.
`default_nettype none

// Each request (rpm byte, gear index, six flags, blink phase) becomes one 24-bit
// frame, sent MSB first as 24 response beats: the gear segment byte, the six
// flags inverted, then the 10-LED active-low rpm bar. last_bit marks the 24th
// beat, after which the strobe may be raised. Before each bit is shown as
// valid, its data is held for a setup delay set by SETUP_DELAY_CYCLES and
// counted down by the serializer's setup counter. The frame is built in one
// pass and registered; that register holds the next frame while the current
// one is still shifting, so a new request is accepted as soon as the register
// is free, and the next frame is taken into the shifter in the same cycle as
// the previous last beat is taken. Configuration writes take effect on the next
// cycle; csr_ready is always high and writes to an unmapped index are dropped.
// Write configuration only while no frame is in flight.

module rpm_gear_display_serializer_top
   import rgds_pkg::*;
#(
   parameter int SETUP_DELAY_CYCLES = SETUP_DELAY_DEFAULT
)(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire req_type                  req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rsp_type                       rsp_data,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [1:0]               csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type        cfg;
   frame_beat_type frame_beat;
   logic           frame_take;

   // Hold the three configuration registers.
   rgds_csr_regs u_csr_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Build the frame and park it until the serializer frees up.
   rgds_frame_builder u_frame_builder (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .cfg        (cfg),
      .frame_take (frame_take),
      .frame_out  (frame_beat)
   );

   // Shift the frame out, one beat per bit.
   rgds_serializer #(
      .SETUP_DELAY_CYCLES (SETUP_DELAY_CYCLES)
   ) u_serializer (
      .clock      (clock),
      .reset      (reset),
      .frame_in   (frame_beat),
      .frame_take (frame_take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
